// ===== rtl/core/aes_pkg.sv =====
`timescale 1ns / 1ps
package aes_pkg;

  localparam int ROUNDS = 14;
  localparam int KEY_BYTES = 32;
  localparam int KEY_WORDS = KEY_BYTES / 4;
  localparam int SCHED_WORDS = 4 * (ROUNDS + 1);

  typedef struct packed {
    logic        op;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1b;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
  endfunction

endpackage

// ===== rtl/core/aes_round.sv =====
`timescale 1ns / 1ps
// One cipher round, combinational: forward or inverse, with or without mix.
module aes_round
  import aes_pkg::*;
(
  input  logic         dec,
  input  logic         mix,
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  output logic [127:0] state_out
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] k [16];
  logic [7:0] u [16];
  logic [7:0] m [16];

  always_comb begin
    logic [7:0] a, b, d, e, a2, b2, d2, e2, a4, b4, d4, e4, a8, b8, d8, e8;
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8*i -: 8];
      k[i] = round_key[127 - 8*i -: 8];
    end
    // substitute and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          t[4*((c + r) % 4) + r] = INV_BOX[s[4*c + r]];
        end else begin
          t[4*c + r] = FWD_BOX[s[4*((c + r) % 4) + r]];
        end
      end
    end
    // inverse order adds the key before the mix
    for (int i = 0; i < 16; i++) begin
      u[i] = dec ? (t[i] ^ k[i]) : t[i];
    end
    for (int c = 0; c < 4; c++) begin
      a = u[4*c]; b = u[4*c+1]; d = u[4*c+2]; e = u[4*c+3];
      a2 = xtime(a); b2 = xtime(b); d2 = xtime(d); e2 = xtime(e);
      a4 = xtime(a2); b4 = xtime(b2); d4 = xtime(d2); e4 = xtime(e2);
      a8 = xtime(a4); b8 = xtime(b4); d8 = xtime(d4); e8 = xtime(e4);
      if (dec) begin
        m[4*c]   = (a8^a4^a2) ^ (b8^b2^b) ^ (d8^d4^d) ^ (e8^e);
        m[4*c+1] = (a8^a) ^ (b8^b4^b2) ^ (d8^d2^d) ^ (e8^e4^e);
        m[4*c+2] = (a8^a4^a) ^ (b8^b) ^ (d8^d4^d2) ^ (e8^e2^e);
        m[4*c+3] = (a8^a2^a) ^ (b8^b4^b) ^ (d8^d) ^ (e8^e4^e2);
      end else begin
        m[4*c]   = a2 ^ (b2^b) ^ d ^ e;
        m[4*c+1] = a ^ b2 ^ (d2^d) ^ e;
        m[4*c+2] = a ^ b ^ d2 ^ (e2^e);
        m[4*c+3] = (a2^a) ^ b ^ d ^ e2;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (!mix) begin
        state_out[127 - 8*i -: 8] = u[i] ^ (dec ? 8'h00 : k[i]);
      end else if (dec) begin
        state_out[127 - 8*i -: 8] = m[i];
      end else begin
        state_out[127 - 8*i -: 8] = m[i] ^ k[i];
      end
    end
  end

endmodule

// ===== rtl/core/aes256_ecb_block_cipher.sv =====
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// input    start & !busy         item_in  (op, block_hi, block_lo)
// output   done, one cycle       item_out (result_hi, result_lo)
// config   APB write, 64-bit     key_word0..3 at 0x00/0x08/0x10/0x18
// One item may enter every cycle while busy is low; the result passes through
// one pipeline stage per cipher round plus the key-add stage.
// After reset or a key write the schedule is rebuilt, one word a cycle
// through the 60-word store; busy is high only meanwhile.
// The user must make key writes only while no item is in flight; not enforced.
// The receiver cannot stall, so the pipeline never holds.
module aes256_ecb_block_cipher
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  aes_in_t      item_in,
  output logic         done,
  output aes_out_t     item_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int NSTG = ROUNDS + 1;

  logic [63:0] key_word [4];
  logic [31:0] rk [SCHED_WORDS];
  logic [5:0]  exp_idx;
  logic        expanding;
  logic [7:0]  rcon;

  logic         vld [NSTG];
  logic         opr [NSTG];
  logic [127:0] st  [NSTG];

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = expanding;
  assign prdata = (paddr[4:3] == 2'd0) ? key_word[0] :
                  (paddr[4:3] == 2'd1) ? key_word[1] :
                  (paddr[4:3] == 2'd2) ? key_word[2] : key_word[3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
    end else if (cfg_wr) begin
      key_word[paddr[4:3]] <= pwdata;
    end
  end

  // key schedule expansion, one word a cycle
  logic [31:0] kt, kn;
  always_comb begin
    kt = rk[exp_idx - 6'd1];
    if (exp_idx[2:0] == 3'd0) begin
      kt = sub_word({kt[23:0], kt[31:24]}) ^ {rcon, 24'h0};
    end else if (exp_idx[2:0] == 3'd4) begin
      kt = sub_word(kt);
    end
    kn = rk[exp_idx - 6'(KEY_WORDS)] ^ kt;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      expanding <= 1'b1;
      exp_idx   <= 6'd0;
    end else if (expanding) begin
      if (exp_idx == 6'(SCHED_WORDS - 1)) expanding <= 1'b0;
      exp_idx <= exp_idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (expanding) begin
      if (exp_idx < 6'(KEY_WORDS)) begin
        rk[exp_idx] <= exp_idx[0] ? key_word[exp_idx[2:1]][31:0]
                                  : key_word[exp_idx[2:1]][63:32];
        rcon <= 8'h01;
      end else begin
        rk[exp_idx] <= kn;
        if (exp_idx[2:0] == 3'd0) rcon <= xtime(rcon);
      end
    end
  end

  // stage 0: initial key add
  logic accept;
  assign accept = start && !busy;
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= accept;
    opr[0] <= item_in.op;
    st[0]  <= {item_in.block_hi, item_in.block_lo} ^ (item_in.op ?
              {rk[56], rk[57], rk[58], rk[59]} : {rk[0], rk[1], rk[2], rk[3]});
  end

  // round stages
  for (genvar g = 1; g < NSTG; g++) begin : g_rnd
    logic [127:0] nxt;
    logic [127:0] key;
    assign key = opr[g-1] ?
      {rk[4*(ROUNDS-g)], rk[4*(ROUNDS-g)+1], rk[4*(ROUNDS-g)+2], rk[4*(ROUNDS-g)+3]} :
      {rk[4*g], rk[4*g+1], rk[4*g+2], rk[4*g+3]};
    aes_round u_round (
      .dec       (opr[g-1]),
      .mix       (g != ROUNDS),
      .state_in  (st[g-1]),
      .round_key (key),
      .state_out (nxt)
    );
    always_ff @(posedge clk) begin
      if (rst) vld[g] <= 1'b0;
      else     vld[g] <= vld[g-1];
      opr[g] <= opr[g-1];
      st[g]  <= nxt;
    end
  end

  assign done = vld[NSTG-1];
  assign item_out.result_hi = st[NSTG-1][127:64];
  assign item_out.result_lo = st[NSTG-1][63:0];

  a_done_no_x: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(item_out)) else $error("result unknown");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##15 done) else $error("result missing");
  a_no_accept_expand: assert property (@(posedge clk) disable iff (rst)
    expanding |-> !accept) else $error("item taken during expansion");

endmodule
